### rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_X = 8'h78;

	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_QUOTE     = 3'd1,
		ERR_EARLY_END = 3'd2,
		ERR_X_HEX     = 3'd3,
		ERR_U_HEX     = 3'd4,
		ERR_PAIR      = 3'd5,
		ERR_ESCAPE    = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		JOB_RAW    = 2'd0,
		JOB_CP     = 2'd1,
		JOB_STATUS = 2'd2
	} job_type_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] out_kind;
		logic [2:0] error_code;
		logic       out_last;
	} out_t;

	// Work handed from the classifier to the emitter.
	typedef struct packed {
		job_type_t   jtype;
		logic [20:0] value;
		kind_t       kind;
		err_t        code;
	} job_t;

endpackage

### rtl/core/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Unescapes one quoted JSON string per in_last-delimited run of bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with in_data (byte, last flag), one byte
// per item, quotes included. Output channel: out_valid/out_ready with
// out_data (byte, kind, error code, last flag).
// Each input byte yields zero to four results: a plain or simple-escaped
// byte gives one, \u code points give 1 to 4 UTF-8 bytes, the final byte
// gives a done or error status, and only the first error of a string is
// reported; the rest of that string is dropped.
// Throughput: one input byte per cycle while the job queue has room; the
// emitter sends one result per cycle while the receiver takes them, so a
// multi-byte code point holds the emitter until all its UTF-8 bytes are
// sent and the queue (QUEUE_DEPTH jobs) absorbs the burst. A byte's job is
// written into the queue; its results then pass the output register.
// Reset clears the parser to expect an opening quote and empties the queue
// and output register. When the receiver stalls, the output item holds,
// the queue fills and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module json_string_unescape #(
	parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  jsu_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output jsu_pkg::out_t out_data
);

	logic          q_full, push, pop, head_valid;
	jsu_pkg::job_t push_job, head_job;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

### rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape parser: tracks the string phase and turns each byte into at most
// one job (raw byte, code point or status) for the emitter.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  jsu_pkg::in_t   in_data,
	input  logic           q_full,
	output logic           push,
	output jsu_pkg::job_t  push_job
);

	typedef enum logic [8:0] {
		ST_START   = 9'b000000001,
		ST_BODY    = 9'b000000010,
		ST_ESC     = 9'b000000100,
		ST_XHEX    = 9'b000001000,
		ST_UHEX    = 9'b000010000,
		ST_PAIR_BS = 9'b000100000,
		ST_PAIR_U  = 9'b001000000,
		ST_LHEX    = 9'b010000000,
		ST_DROP    = 9'b100000000
	} state_t;

	state_t      st_q, st_d;
	logic [1:0]  dig_q, dig_d;
	logic        bad_q, bad_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hs_q, hs_d;

	logic        accept;
	logic        hv_ok;
	logic [3:0]  hv;
	logic [15:0] acc_sh;
	logic [7:0]  b;
	logic        has_job;
	jsu_pkg::job_t job;

	function automatic jsu_pkg::job_t status_job(jsu_pkg::kind_t k, jsu_pkg::err_t c);
		jsu_pkg::job_t j;
		j = '0;
		j.jtype = jsu_pkg::JOB_STATUS;
		j.kind = k;
		j.code = c;
		return j;
	endfunction

	function automatic jsu_pkg::job_t data_job(jsu_pkg::job_type_t t, logic [20:0] v);
		jsu_pkg::job_t j;
		j = '0;
		j.jtype = t;
		j.value = v;
		j.kind = jsu_pkg::KIND_DATA;
		j.code = jsu_pkg::ERR_NONE;
		return j;
	endfunction

	assign b = in_data.in_byte;
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		hv_ok = 1'b1;
		hv = '0;
		if (b inside {[8'h30:8'h39]}) begin
			hv = b[3:0];
		end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hv = 4'(b[3:0] + 4'd9);
		end else begin
			hv_ok = 1'b0;
		end
	end

	assign acc_sh = {acc_q[11:0], hv};

	always_comb begin
		st_d = st_q;
		dig_d = dig_q;
		bad_d = bad_q;
		acc_d = acc_q;
		hs_d = hs_q;
		has_job = 1'b0;
		job = '0;
		if (in_data.in_last) begin
			st_d = ST_START;
			dig_d = '0;
			bad_d = 1'b0;
			if (st_q != ST_DROP) begin
				has_job = 1'b1;
				if (st_q == ST_START || b != jsu_pkg::CH_QUOTE) begin
					job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_QUOTE);
				end else if (st_q == ST_BODY) begin
					job = status_job(jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
				end else begin
					job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_EARLY_END);
				end
			end
		end else begin
			case (st_q)
				ST_START: begin
					if (b == jsu_pkg::CH_QUOTE) begin
						st_d = ST_BODY;
					end else begin
						has_job = 1'b1;
						job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_QUOTE);
						st_d = ST_DROP;
					end
				end
				ST_BODY: begin
					if (b == jsu_pkg::CH_BSLASH) begin
						st_d = ST_ESC;
					end else begin
						has_job = 1'b1;
						job = data_job(jsu_pkg::JOB_RAW, 21'(b));
					end
				end
				ST_ESC: begin
					st_d = ST_BODY;
					dig_d = '0;
					bad_d = 1'b0;
					has_job = 1'b1;
					case (b)
						jsu_pkg::CH_BSLASH: job = data_job(jsu_pkg::JOB_RAW, 21'(jsu_pkg::CH_BSLASH));
						jsu_pkg::CH_QUOTE:  job = data_job(jsu_pkg::JOB_RAW, 21'(jsu_pkg::CH_QUOTE));
						jsu_pkg::CH_B:      job = data_job(jsu_pkg::JOB_RAW, 21'h08);
						jsu_pkg::CH_F:      job = data_job(jsu_pkg::JOB_RAW, 21'h0C);
						jsu_pkg::CH_N:      job = data_job(jsu_pkg::JOB_RAW, 21'h0A);
						jsu_pkg::CH_R:      job = data_job(jsu_pkg::JOB_RAW, 21'h0D);
						jsu_pkg::CH_T:      job = data_job(jsu_pkg::JOB_RAW, 21'h09);
						jsu_pkg::CH_X: begin
							has_job = 1'b0;
							st_d = ST_XHEX;
						end
						jsu_pkg::CH_U: begin
							has_job = 1'b0;
							st_d = ST_UHEX;
						end
						default: begin
							job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_ESCAPE);
							st_d = ST_DROP;
						end
					endcase
				end
				ST_XHEX: begin
					if (dig_q == 2'd0) begin
						acc_d = acc_sh;
						bad_d = !hv_ok;
						dig_d = 2'd1;
					end else begin
						has_job = 1'b1;
						if (bad_q || !hv_ok) begin
							job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_X_HEX);
							st_d = ST_DROP;
						end else begin
							job = data_job(jsu_pkg::JOB_RAW, 21'(acc_sh[7:0]));
							st_d = ST_BODY;
						end
					end
				end
				ST_UHEX, ST_LHEX: begin
					acc_d = acc_sh;
					if (dig_q != 2'd3) begin
						// a bad digit still uses up the remaining digit slots
						dig_d = 2'(dig_q + 2'd1);
						bad_d = bad_q || !hv_ok;
					end else if (bad_q || !hv_ok) begin
						has_job = 1'b1;
						job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_U_HEX);
						st_d = ST_DROP;
					end else if (st_q == ST_UHEX) begin
						if (acc_sh[15:10] == jsu_pkg::HI_SURR_TAG) begin
							hs_d = acc_sh[9:0];
							bad_d = 1'b0;
							st_d = ST_PAIR_BS;
						end else begin
							has_job = 1'b1;
							job = data_job(jsu_pkg::JOB_CP, 21'(acc_sh));
							st_d = ST_BODY;
						end
					end else begin
						has_job = 1'b1;
						if (acc_sh[15:10] == jsu_pkg::LO_SURR_TAG) begin
							job = data_job(jsu_pkg::JOB_CP,
								21'({hs_q, acc_sh[9:0]}) + jsu_pkg::SUPP_BASE);
							st_d = ST_BODY;
						end else begin
							job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_ESCAPE);
							st_d = ST_DROP;
						end
					end
				end
				ST_PAIR_BS: begin
					bad_d = (b != jsu_pkg::CH_BSLASH);
					st_d = ST_PAIR_U;
				end
				ST_PAIR_U: begin
					if (bad_q || b != jsu_pkg::CH_U) begin
						has_job = 1'b1;
						job = status_job(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_PAIR);
						st_d = ST_DROP;
					end else begin
						dig_d = '0;
						bad_d = 1'b0;
						st_d = ST_LHEX;
					end
				end
				ST_DROP: begin
				end
				default: st_d = ST_START;
			endcase
		end
	end

	assign push = accept && has_job;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_START;
			dig_q <= '0;
			bad_q <= 1'b0;
		end else if (accept) begin
			st_q <= st_d;
			dig_q <= dig_d;
			bad_q <= bad_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_d;
			hs_q <= hs_d;
		end
	end

endmodule

### rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small circular job queue between parser and emitter.
// ----------------------------------------------------------------------------
module jsu_queue #(
	parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jsu_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output jsu_pkg::job_t  head_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	jsu_pkg::job_t          slots_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   do_push, do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= push_job;
	end

endmodule

### rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Emitter: expands the head job into one to four result items (UTF-8 bytes
// for a code point) and drives the registered output.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  jsu_pkg::job_t  head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output jsu_pkg::out_t  out_data
);

	logic [1:0]       idx_q;
	logic [1:0]       nm1;
	logic [3:0][7:0]  pcs;
	logic [20:0]      cp;
	logic             piece_last;
	logic             adv;
	logic             out_valid_q;
	jsu_pkg::out_t    out_q;
	jsu_pkg::out_t    piece;

	assign cp = head_job.value;

	always_comb begin
		pcs = '0;
		nm1 = 2'd0;
		case (head_job.jtype)
			jsu_pkg::JOB_CP: begin
				if (cp[20:7] == '0) begin
					pcs[0] = {1'b0, cp[6:0]};
				end else if (cp[20:11] == '0) begin
					nm1 = 2'd1;
					pcs[0] = {3'b110, cp[10:6]};
					pcs[1] = {2'b10, cp[5:0]};
				end else if (cp[20:16] == '0) begin
					nm1 = 2'd2;
					pcs[0] = {4'b1110, cp[15:12]};
					pcs[1] = {2'b10, cp[11:6]};
					pcs[2] = {2'b10, cp[5:0]};
				end else begin
					nm1 = 2'd3;
					pcs[0] = {5'b11110, cp[20:18]};
					pcs[1] = {2'b10, cp[17:12]};
					pcs[2] = {2'b10, cp[11:6]};
					pcs[3] = {2'b10, cp[5:0]};
				end
			end
			jsu_pkg::JOB_RAW: pcs[0] = cp[7:0];
			default: pcs = '0;
		endcase
	end

	assign piece_last = (idx_q == nm1);

	always_comb begin
		piece.out_byte = pcs[idx_q];
		piece.out_kind = head_job.kind;
		piece.error_code = head_job.code;
		piece.out_last = piece_last;
	end

	// output register frees up whenever it is empty or being taken
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && head_valid && piece_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (head_valid) idx_q <= piece_last ? 2'd0 : 2'(idx_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid) out_q <= piece;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

### rtl/core/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the unescaper's output channel.
// ----------------------------------------------------------------------------
module jsu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input jsu_pkg::out_t out_data
);

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// status items always close the results of their byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind != jsu_pkg::KIND_DATA |-> out_data.out_last)
		else $error("status item without last flag");

	a_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_kind == jsu_pkg::KIND_DATA &&
			out_data.error_code == jsu_pkg::ERR_NONE) ||
			(out_data.out_kind != jsu_pkg::KIND_DATA && out_data.out_byte == 8'h00))
		else $error("unused output field not zero");

	a_code_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_kind == jsu_pkg::KIND_ERROR) ==
			(out_data.error_code != jsu_pkg::ERR_NONE))
		else $error("error code does not match kind");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
